@@ rtl/core/chg_pkg.sv @@
// Shared types, constants and threshold tables for the core hotplug governor.
// Used by every module of the governor; depends on nothing else.
`default_nettype none

package chg_pkg;

  localparam int NUM_CORES      = 4;
  localparam int LOAD_FRAC_BITS = 11;
  localparam int LOAD_W         = 20;
  localparam int LANES          = 3;
  localparam int HYST_W         = 8;
  localparam int THR_W          = 5;
  localparam int SUM_W          = 9;
  localparam int CMP_W          = (SUM_W + LOAD_FRAC_BITS > LOAD_W) ?
                                  (SUM_W + LOAD_FRAC_BITS) : LOAD_W;
  localparam int MASK_W         = 4;
  localparam int LVL_W          = 3;
  localparam int HOLD_W         = 4;
  localparam int PROF_W         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 20;
  localparam int IN_DATA_W      = 80;
  localparam int OUT_DATA_W     = 16;

  localparam int SAMPLE_MS      = 268;
  localparam int CAP_PER_THREAD = 339 - 50;

  localparam int THR_380  = (CAP_PER_THREAD * 380 * 4) / 100000;
  localparam int THR_625  = (CAP_PER_THREAD * 625 * 4) / 100000;
  localparam int THR_750  = (CAP_PER_THREAD * 750 * 4) / 100000;
  localparam int THR_875  = (CAP_PER_THREAD * 875 * 4) / 100000;
  localparam int THR_1125 = (CAP_PER_THREAD * 1125 * 4) / 100000;
  localparam int THR_1625 = (CAP_PER_THREAD * 1625 * 4) / 100000;
  localparam int THR_2125 = (CAP_PER_THREAD * 2125 * 4) / 100000;

  localparam logic [HOLD_W-1:0] HOLD_TWO   = HOLD_W'(2500 / SAMPLE_MS);
  localparam logic [HOLD_W-1:0] HOLD_THREE = HOLD_W'(1700 / SAMPLE_MS);
  localparam logic [HOLD_W-1:0] HOLD_FOUR  = HOLD_W'(1000 / SAMPLE_MS);
  localparam logic [HOLD_W-1:0] HOLD_WAKE  = HOLD_W'(3500 / SAMPLE_MS);

  localparam logic [MASK_W-1:0] CORE_MASK = MASK_W'((1 << NUM_CORES) - 1);
  localparam logic [MASK_W-1:0] CORE_ZERO = MASK_W'(1);

  localparam logic [PROF_W-1:0] PROF_BALANCE      = 3'd0;
  localparam logic [PROF_W-1:0] PROF_PERFORMANCE  = 3'd1;
  localparam logic [PROF_W-1:0] PROF_CONSERVATIVE = 3'd2;
  localparam logic [PROF_W-1:0] PROF_ECO          = 3'd3;
  localparam logic [PROF_W-1:0] PROF_ECO_EXTREME  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PLUG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOUCH_BOOST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROFILE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_THRESH   = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SUSPEND = 2'd1,
    CMD_RESUME  = 2'd2,
    CMD_TOUCH   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              plug_enable;
    logic              touch_boost_enable;
    logic [PROF_W-1:0] profile_select;
    logic [HYST_W-1:0] hysteresis;
    logic [LOAD_W-1:0] core_load_threshold;
  } cfg_t;

  typedef struct packed {
    logic [LANES-1:0] lvl_hit;
    logic [LANES:1]   load_low;
  } tick_flags_t;

  typedef struct packed {
    logic              is_suspended;
    logic [HOLD_W-1:0] hold_count;
    logic [LVL_W-1:0]  run_level;
    logic [MASK_W-1:0] online_mask;
  } result_t;

  function automatic logic [THR_W-1:0] prof_thr(input logic [PROF_W-1:0] prof,
                                                input int idx);
    int v;
    v = 0;
    case (prof)
      PROF_BALANCE:      v = (idx == 0) ? THR_625 : (idx == 1) ? THR_875 : THR_1125;
      PROF_PERFORMANCE:  v = (idx == 0) ? THR_380 : (idx == 1) ? THR_625 : THR_875;
      PROF_CONSERVATIVE: v = (idx == 0) ? THR_875 : (idx == 1) ? THR_1625 : THR_2125;
      PROF_ECO:          v = (idx == 0) ? THR_380 : 0;
      PROF_ECO_EXTREME:  v = (idx == 0) ? THR_750 : 0;
      default:           v = 0;
    endcase
    return THR_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/chg_lvl_lane.sv @@
// One level lane: tests the average run queue against one widened threshold.
// Depends on chg_pkg.
`default_nettype none

module chg_lvl_lane (
  input  wire logic [chg_pkg::THR_W-1:0]  thr,
  input  wire logic                       add_hyst,
  input  wire logic [chg_pkg::HYST_W-1:0] hysteresis,
  input  wire logic                       small_shift,
  input  wire logic [chg_pkg::LOAD_W-1:0] avg,
  output logic                            hit
);
  import chg_pkg::*;

  logic [SUM_W-1:0] sum;
  logic [CMP_W-1:0] lim_small;
  logic [CMP_W-1:0] lim_large;

  assign sum       = SUM_W'(thr) + (add_hyst ? SUM_W'(hysteresis) : SUM_W'(0));
  assign lim_small = CMP_W'(sum) << (LOAD_FRAC_BITS - 1);
  assign lim_large = CMP_W'(sum) << (LOAD_FRAC_BITS - (NUM_CORES - 1));
  assign hit       = CMP_W'(avg) <= (small_shift ? lim_small : lim_large);

endmodule

`default_nettype wire

@@ rtl/core/chg_load_lane.sv @@
// One core lane: flags a core whose load is below the drop threshold.
// Depends on chg_pkg.
`default_nettype none

module chg_load_lane (
  input  wire logic [chg_pkg::LOAD_W-1:0] load,
  input  wire logic [chg_pkg::LOAD_W-1:0] threshold,
  output logic                            low
);
  import chg_pkg::*;

  assign low = load < threshold;

endmodule

`default_nettype wire

@@ rtl/core/chg_update.sv @@
// Merge stage: combines the lane results into a level and updates the governor state.
// The state registers double as the result beat. Depends on chg_pkg.
`default_nettype none

module chg_update (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire chg_pkg::cmd_t        cmd,
  input  wire chg_pkg::tick_flags_t flags,
  input  wire chg_pkg::cfg_t        cfg,
  output chg_pkg::result_t          state
);
  import chg_pkg::*;

  logic [MASK_W-1:0] core_online, core_online_next;
  logic [LVL_W-1:0]  last_level, last_level_next;
  logic [HOLD_W-1:0] hold_ticks, hold_ticks_next;
  logic              suspend_flag, suspend_flag_next;

  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  n_online;
  logic [HOLD_W-1:0] hold_dec;
  logic              wide_table;

  function automatic logic [MASK_W-1:0] drop_cores(input logic [MASK_W-1:0] online,
                                                   input int keep_upto,
                                                   input logic [LANES:1] low);
    logic [MASK_W-1:0] m;
    m = online;
    for (int c = 1; c < NUM_CORES && c <= LANES; c++) begin
      if (online[c] && c > keep_upto && low[c]) begin
        m[c] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [MASK_W-1:0] raise_cores(input logic [MASK_W-1:0] online,
                                                    input int count);
    logic [MASK_W-1:0] m;
    m = online;
    for (int i = 1; i < MASK_W; i++) begin
      if (i < count) begin
        m[i] = 1'b1;
      end
    end
    return m & CORE_MASK;
  endfunction

  always_comb begin
    n_online = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n_online = n_online + LVL_W'(core_online[i]);
    end
  end

  assign wide_table = (NUM_CORES > 2) && (cfg.profile_select < PROF_ECO);

  always_comb begin
    if (wide_table) begin
      if (flags.lvl_hit[0]) begin
        lvl = LVL_W'(1);
      end else if (flags.lvl_hit[1]) begin
        lvl = LVL_W'(2);
      end else if (flags.lvl_hit[2]) begin
        lvl = LVL_W'(3);
      end else begin
        lvl = LVL_W'(4);
      end
    end else begin
      lvl = flags.lvl_hit[0] ? LVL_W'(1) : LVL_W'(2);
    end
  end

  assign hold_dec = (hold_ticks != '0) ? hold_ticks - HOLD_W'(1) : hold_ticks;

  always_comb begin
    core_online_next  = core_online;
    last_level_next   = last_level;
    hold_ticks_next   = hold_ticks;
    suspend_flag_next = suspend_flag;
    if (cfg.plug_enable) begin
      unique case (cmd)
        CMD_TICK: begin
          last_level_next = lvl;
          if (!suspend_flag) begin
            hold_ticks_next = hold_dec;
            if (lvl == LVL_W'(1)) begin
              if (hold_dec == '0) begin
                core_online_next = drop_cores(core_online, 0, flags.load_low);
              end
            end else if (lvl == LVL_W'(2)) begin
              if (hold_dec == '0) begin
                hold_ticks_next = HOLD_TWO;
              end
              core_online_next = (n_online < LVL_W'(2)) ? raise_cores(core_online, 2) :
                                 drop_cores(core_online, 1, flags.load_low);
            end else if (lvl == LVL_W'(3)) begin
              if (hold_dec == '0) begin
                hold_ticks_next = HOLD_THREE;
              end
              core_online_next = (n_online < LVL_W'(3)) ? raise_cores(core_online, 3) :
                                 drop_cores(core_online, 2, flags.load_low);
            end else begin
              if (hold_dec == '0) begin
                hold_ticks_next = HOLD_FOUR;
              end
              if (n_online < LVL_W'(4)) begin
                core_online_next = raise_cores(core_online, 4);
              end
            end
          end
        end
        CMD_SUSPEND: begin
          suspend_flag_next = 1'b1;
          core_online_next  = CORE_ZERO;
        end
        CMD_RESUME: begin
          hold_ticks_next   = HOLD_WAKE;
          suspend_flag_next = 1'b0;
          core_online_next  = CORE_MASK;
        end
        CMD_TOUCH: begin
          if (cfg.touch_boost_enable && n_online < LVL_W'(2)) begin
            core_online_next = (core_online | MASK_W'(2)) & CORE_MASK;
          end
        end
        default: begin
          core_online_next = core_online;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      core_online  <= CORE_ZERO;
      last_level   <= '0;
      hold_ticks   <= '0;
      suspend_flag <= 1'b0;
    end else if (step) begin
      core_online  <= core_online_next;
      last_level   <= last_level_next;
      hold_ticks   <= hold_ticks_next;
      suspend_flag <= suspend_flag_next;
    end
  end

  assign state.online_mask  = core_online;
  assign state.run_level    = last_level;
  assign state.hold_count   = hold_ticks;
  assign state.is_suspended = suspend_flag;

endmodule

`default_nettype wire

@@ rtl/core/cpu_core_hotplug_governor_unit.sv @@
// Top level of the core hotplug governor: input stage, level and core lanes, merge stage.
// Depends on chg_pkg, chg_lvl_lane, chg_load_lane and chg_update.
`default_nettype none

// Each input beat is one event: a sampling tick, suspend, resume or touch. A beat is
// registered in the input stage and settled by the merge stage once the output can take
// it; the merge stage writes the governor state, the result beat, one per event. Events
// stream at one per cycle while results are taken, passing the input register and then
// the state register. The user must write configuration through cfg_we, cfg_index and
// cfg_data only while no event is in flight; the block does not enforce this.
module cpu_core_hotplug_governor_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [chg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [chg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // avg_run_queue, core1_load, core2_load, core3_load
  input  wire logic [chg_pkg::IN_DATA_W-1:0]     s_tdata,
  // cmd
  input  wire logic [1:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // online_mask, run_level, hold_count, is_suspended, zero fill
  output logic [chg_pkg::OUT_DATA_W-1:0]         m_tdata
);
  import chg_pkg::*;

  cfg_t              cfg;
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic [LOAD_W-1:0] s1_avg;
  logic [LOAD_W-1:0] s1_load [1:LANES];
  logic              step;
  logic              small_shift;
  tick_flags_t       flags;
  result_t           state;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plug_enable         <= 1'b0;
      cfg.touch_boost_enable  <= 1'b1;
      cfg.profile_select      <= PROF_BALANCE;
      cfg.hysteresis          <= HYST_W'(8);
      cfg.core_load_threshold <= LOAD_W'(722);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLUG_ENABLE: cfg.plug_enable         <= cfg_data[0];
        REG_TOUCH_BOOST: cfg.touch_boost_enable  <= cfg_data[0];
        REG_PROFILE:     cfg.profile_select      <= cfg_data[PROF_W-1:0];
        REG_HYSTERESIS:  cfg.hysteresis          <= cfg_data[HYST_W-1:0];
        REG_LOAD_THRESH: cfg.core_load_threshold <= cfg_data[LOAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign step     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_cmd <= cmd_t'(s_tuser);
      s1_avg <= s_tdata[LOAD_W-1:0];
      for (int i = 1; i <= LANES; i++) begin
        s1_load[i] <= s_tdata[i*LOAD_W +: LOAD_W];
      end
    end
  end

  assign small_shift = cfg.profile_select >= PROF_ECO;

  for (genvar g = 0; g < LANES; g++) begin : g_lanes
    chg_lvl_lane u_lvl (
      .thr        (prof_thr(cfg.profile_select, g)),
      .add_hyst   (state.run_level <= LVL_W'(g + 1)),
      .hysteresis (cfg.hysteresis),
      .small_shift(small_shift),
      .avg        (s1_avg),
      .hit        (flags.lvl_hit[g])
    );

    chg_load_lane u_load (
      .load      (s1_load[g+1]),
      .threshold (cfg.core_load_threshold),
      .low       (flags.load_low[g+1])
    );
  end

  chg_update u_update (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .cmd   (s1_cmd),
    .flags (flags),
    .cfg   (cfg),
    .state (state)
  );

  assign m_tdata = OUT_DATA_W'(state);

`ifndef SYNTHESIS
  a_core_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state.online_mask[0])
    else $error("core zero went offline");

  a_suspend_mask: assert property (@(posedge clk) disable iff (rst)
    state.is_suspended |-> (state.online_mask[MASK_W-1:2] == '0))
    else $error("upper cores online during suspend");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are full");

  a_step_gives_beat: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("state update without a result beat");
`endif

endmodule

`default_nettype wire
